// ===== rtl/rcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants of the rectangle coverage mask block.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int MASK_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // in_tdata layout, lowest bit first
  localparam int RECT_INDEX_LSB  = 0;
  localparam int RECT_LEFT_LSB   = RECT_INDEX_LSB + IDX_W;
  localparam int RECT_TOP_LSB    = RECT_LEFT_LSB + COORD_W;
  localparam int RECT_RIGHT_LSB  = RECT_TOP_LSB + COORD_W;
  localparam int RECT_BOTTOM_LSB = RECT_RIGHT_LSB + COORD_W;
  localparam int CELL_X_LSB      = RECT_BOTTOM_LSB + COORD_W;
  localparam int CELL_Y_LSB      = CELL_X_LSB + COORD_W;
  localparam int IN_FIELDS_W     = CELL_Y_LSB + COORD_W;
  localparam int IN_TDATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W     = MASK_W;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_COUNT  = 3'd0,
    REG_AREA_LEFT   = 3'd1,
    REG_AREA_TOP    = 3'd2,
    REG_AREA_RIGHT  = 3'd3,
    REG_AREA_BOTTOM = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/rcm_rect_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_rect_store
// Rectangle slots with one parallel cell compare per slot.
// ----------------------------------------------------------------------------
module rcm_rect_store #(
  parameter int MAX_RECTS = 32,
  parameter int CW        = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [rcm_pkg::IDX_W-1:0]  wr_index,
  input  logic [CW-1:0]              wr_left,
  input  logic [CW-1:0]              wr_top,
  input  logic [CW-1:0]              wr_right,
  input  logic [CW-1:0]              wr_bottom,
  input  logic [CW-1:0]              cell_x,
  input  logic [CW-1:0]              cell_y,
  input  logic [rcm_pkg::CNT_W-1:0]  rect_count,
  output logic [MAX_RECTS-1:0]       hit
);

  localparam int IW = rcm_pkg::IDX_W;
  localparam int NW = rcm_pkg::CNT_W;

  logic [CW-1:0] left_r   [MAX_RECTS];
  logic [CW-1:0] top_r    [MAX_RECTS];
  logic [CW-1:0] right_r  [MAX_RECTS];
  logic [CW-1:0] bottom_r [MAX_RECTS];

  for (genvar g = 0; g < MAX_RECTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        left_r[g]   <= '0;
        top_r[g]    <= '0;
        right_r[g]  <= '0;
        bottom_r[g] <= '0;
      end else if (wr_en && (wr_index == IW'(g))) begin
        left_r[g]   <= wr_left;
        top_r[g]    <= wr_top;
        right_r[g]  <= wr_right;
        bottom_r[g] <= wr_bottom;
      end
    end

    assign hit[g] = (rect_count > NW'(g)) &&
                    (cell_x >= left_r[g]) && (cell_x <= right_r[g]) &&
                    (cell_y >= top_r[g])  && (cell_y <= bottom_r[g]);
  end

endmodule

// ===== rtl/rectangle_coverage_mask_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_coverage_mask_top
// Tests a grid cell against up to MAX_RECTS stored rectangles at once.
//
// Input channel: in_tuser selects a rectangle write or a cell query. A write
// stores one rectangle in a slot and gives no result; a query gives one
// result on the output channel: a coverage mask (bit i set when rectangle i,
// i below rect_count, covers the cell) and an in-area flag. Cells outside the
// configured area give a zero mask.
// Config channel: always ready; write only while no item is in flight.
// A query's result passes the input register, then the result register.
// Throughput: one item per cycle while the receiver keeps up, set by the
// single compare stage with all rectangle lanes side by side.
// Reset clears the slots, the registers (one-cell area at 0,0, count 0) and
// both stages. When the receiver stalls, the result register holds and the
// input register keeps flowing for writes; a query waiting behind a held
// result stalls in_tready.
// ----------------------------------------------------------------------------
module rectangle_coverage_mask_top #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rect_index, rect_left, rect_top, rect_right, rect_bottom, cell_x, cell_y
  input  logic [rcm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // coverage_mask
  output logic [rcm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // in_area
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = (COORD_BITS < rcm_pkg::COORD_W) ? COORD_BITS : rcm_pkg::COORD_W;

  // configuration registers
  logic [rcm_pkg::CNT_W-1:0] rect_count_r;
  logic [CW-1:0]             area_left_r;
  logic [CW-1:0]             area_top_r;
  logic [CW-1:0]             area_right_r;
  logic [CW-1:0]             area_bottom_r;

  // input stage
  logic                      s1_valid_r;
  rcm_pkg::func_t            s1_func_r;
  logic [rcm_pkg::IDX_W-1:0] s1_index_r;
  logic [CW-1:0]             s1_left_r;
  logic [CW-1:0]             s1_top_r;
  logic [CW-1:0]             s1_right_r;
  logic [CW-1:0]             s1_bottom_r;
  logic [CW-1:0]             s1_x_r;
  logic [CW-1:0]             s1_y_r;

  // result stage
  logic                       out_valid_r;
  logic [rcm_pkg::MASK_W-1:0] out_mask_r;
  logic                       out_in_area_r;
  logic [rcm_pkg::MASK_W-1:0] out_mask_nxt;
  logic                       out_in_area_nxt;

  logic                 in_xfer;
  logic                 s1_leave;
  logic                 out_load;
  logic                 store_wr;
  logic [MAX_RECTS-1:0] hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_count_r  <= '0;
      area_left_r   <= '0;
      area_top_r    <= '0;
      area_right_r  <= '0;
      area_bottom_r <= '0;
    end else if (cfg_valid) begin
      unique case (rcm_pkg::cfg_reg_t'(cfg_index))
        rcm_pkg::REG_RECT_COUNT:  rect_count_r  <= cfg_data[rcm_pkg::CNT_W-1:0];
        rcm_pkg::REG_AREA_LEFT:   area_left_r   <= cfg_data[CW-1:0];
        rcm_pkg::REG_AREA_TOP:    area_top_r    <= cfg_data[CW-1:0];
        rcm_pkg::REG_AREA_RIGHT:  area_right_r  <= cfg_data[CW-1:0];
        rcm_pkg::REG_AREA_BOTTOM: area_bottom_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: writes always drain, queries wait for a free result register
  assign store_wr  = s1_valid_r && (s1_func_r == rcm_pkg::FUNC_WRITE);
  assign out_load  = s1_valid_r && (s1_func_r == rcm_pkg::FUNC_QUERY) &&
                     (!out_valid_r || out_tready);
  assign s1_leave  = store_wr || out_load;
  assign in_tready = !s1_valid_r || s1_leave;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r   <= rcm_pkg::func_t'(in_tuser[0]);
      s1_index_r  <= in_tdata[rcm_pkg::RECT_INDEX_LSB +: rcm_pkg::IDX_W];
      s1_left_r   <= in_tdata[rcm_pkg::RECT_LEFT_LSB +: CW];
      s1_top_r    <= in_tdata[rcm_pkg::RECT_TOP_LSB +: CW];
      s1_right_r  <= in_tdata[rcm_pkg::RECT_RIGHT_LSB +: CW];
      s1_bottom_r <= in_tdata[rcm_pkg::RECT_BOTTOM_LSB +: CW];
      s1_x_r      <= in_tdata[rcm_pkg::CELL_X_LSB +: CW];
      s1_y_r      <= in_tdata[rcm_pkg::CELL_Y_LSB +: CW];
    end
  end

  rcm_rect_store #(
    .MAX_RECTS (MAX_RECTS),
    .CW        (CW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (store_wr),
    .wr_index   (s1_index_r),
    .wr_left    (s1_left_r),
    .wr_top     (s1_top_r),
    .wr_right   (s1_right_r),
    .wr_bottom  (s1_bottom_r),
    .cell_x     (s1_x_r),
    .cell_y     (s1_y_r),
    .rect_count (rect_count_r),
    .hit        (hit)
  );

  always_comb begin
    out_in_area_nxt = (s1_x_r >= area_left_r) && (s1_x_r <= area_right_r) &&
                      (s1_y_r >= area_top_r)  && (s1_y_r <= area_bottom_r);
    out_mask_nxt    = out_in_area_nxt ? rcm_pkg::MASK_W'(hit) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask_r    <= out_mask_nxt;
      out_in_area_r <= out_in_area_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_mask_r;
  assign out_tuser[0] = out_in_area_r;

  a_outside_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("cell outside area carries a nonzero mask");

  a_query_waits : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && s1_valid_r &&
     (s1_func_r == rcm_pkg::FUNC_QUERY)) |-> !in_tready)
    else $error("input accepted while a query is blocked by a held result");

  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !s1_valid_r))
    else $error("stages not empty after reset");

endmodule

// ===== tb/rcm_coverage_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_coverage_checker
// Watches the config, input and result channels of the rectangle coverage
// mask block. Keeps its own copy of the rectangle slots and registers,
// predicts mask and in-area flag per query transfer, and compares every
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module rcm_coverage_checker
  import rcm_pkg::*;
#(
  parameter int MAX_RECTS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]            out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } rect_bounds_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              in_area;
  } coverage_t;

  rect_bounds_t       rects [MAX_RECTS];
  logic [CNT_W-1:0]   rect_count;
  logic [COORD_W-1:0] area_left;
  logic [COORD_W-1:0] area_top;
  logic [COORD_W-1:0] area_right;
  logic [COORD_W-1:0] area_bottom;
  coverage_t          expected_hits [$];
  int                 errors;

  function automatic logic covers(input logic [COORD_W-1:0] x, y, l, t, r, b);
    return (x >= l) && (x <= r) && (y >= t) && (y <= b);
  endfunction

  function automatic coverage_t predict_coverage(input logic [COORD_W-1:0] x, y);
    coverage_t res;
    int        active;
    res     = '0;
    active  = (rect_count > MAX_RECTS) ? MAX_RECTS : int'(rect_count);
    res.in_area = covers(x, y, area_left, area_top, area_right, area_bottom);
    if (res.in_area) begin
      for (int i = 0; i < active; i++) begin
        if (covers(x, y, rects[i].left, rects[i].top, rects[i].right, rects[i].bottom))
          res.mask[i] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [MASK_W-1:0] exp_v,
                               input logic [MASK_W-1:0] act_v);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    coverage_t        want;
    logic [IDX_W-1:0] slot;
    if (!rst_n) begin
      foreach (rects[i]) rects[i] = '0;
      rect_count  = '0;
      area_left   = '0;
      area_top    = '0;
      area_right  = '0;
      area_bottom = '0;
      expected_hits.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_RECT_COUNT:  rect_count  = cfg_data[CNT_W-1:0];
          REG_AREA_LEFT:   area_left   = cfg_data[COORD_W-1:0];
          REG_AREA_TOP:    area_top    = cfg_data[COORD_W-1:0];
          REG_AREA_RIGHT:  area_right  = cfg_data[COORD_W-1:0];
          REG_AREA_BOTTOM: area_bottom = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          note_mismatch("result with nothing expected", '0, out_tdata);
        end else begin
          want = expected_hits.pop_front();
          if (out_tdata !== want.mask)
            note_mismatch("coverage_mask", want.mask, out_tdata);
          if (out_tuser[0] !== want.in_area)
            note_mismatch("in_area", MASK_W'(want.in_area), MASK_W'(out_tuser[0]));
        end
      end
      if (in_tvalid && in_tready) begin
        if (func_t'(in_tuser[0]) == FUNC_WRITE) begin
          slot = in_tdata[RECT_INDEX_LSB +: IDX_W];
          if (slot < MAX_RECTS) begin
            rects[slot].left   = in_tdata[RECT_LEFT_LSB +: COORD_W];
            rects[slot].top    = in_tdata[RECT_TOP_LSB +: COORD_W];
            rects[slot].right  = in_tdata[RECT_RIGHT_LSB +: COORD_W];
            rects[slot].bottom = in_tdata[RECT_BOTTOM_LSB +: COORD_W];
          end
        end else begin
          want = predict_coverage(in_tdata[CELL_X_LSB +: COORD_W],
                                  in_tdata[CELL_Y_LSB +: COORD_W]);
          expected_hits = {expected_hits, want};
        end
      end
    end
    error_count   <= errors;
    pending_count <= expected_hits.size();
  end

endmodule

// ===== tb/tb_rectangle_coverage_mask_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rectangle_coverage_mask_top
// Drives rectangle writes, cell queries and register writes into the
// rectangle coverage mask block with random idling on both streams; a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rectangle_coverage_mask_top;
  import rcm_pkg::*;

  localparam int MAX_RECTS   = 32;
  localparam int COORD_BITS  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 200;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int                     error_count;
  int                     pending_count;
  int                     cycles     = 0;
  logic                   calm       = 1'b0;
  logic [COORD_W-1:0]     window_base = '0;

  rectangle_coverage_mask_top #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rcm_coverage_checker #(
    .MAX_RECTS (MAX_RECTS)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 34);
  end

  // Hold each item until the transfer; idle in front of it at random.
  task automatic send_item(input func_t func, input logic [IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] l, t, r, b, x, y);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[RECT_INDEX_LSB  +: IDX_W]   = idx;
    d[RECT_LEFT_LSB   +: COORD_W] = l;
    d[RECT_TOP_LSB    +: COORD_W] = t;
    d[RECT_RIGHT_LSB  +: COORD_W] = r;
    d[RECT_BOTTOM_LSB +: COORD_W] = b;
    d[CELL_X_LSB      +: COORD_W] = x;
    d[CELL_Y_LSB      +: COORD_W] = y;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_rect(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] l, t, r, b);
    send_item(FUNC_WRITE, idx, l, t, r, b, COORD_W'($urandom()), COORD_W'($urandom()));
  endtask

  task automatic query_cell(input logic [COORD_W-1:0] x, y);
    send_item(FUNC_QUERY, IDX_W'($urandom()),
              COORD_W'($urandom()), COORD_W'($urandom()),
              COORD_W'($urandom()), COORD_W'($urandom()), x, y);
  endtask

  // Drop valid, wait for every result, then let in-flight writes drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Hold valid high across back-to-back register writes.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] cnt, l, t, r, b);
    wait_idle();
    write_reg(REG_RECT_COUNT, cnt);
    write_reg(REG_AREA_LEFT, l);
    write_reg(REG_AREA_TOP, t);
    write_reg(REG_AREA_RIGHT, r);
    write_reg(REG_AREA_BOTTOM, b);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return '0;
    if (roll < 10) return '1;
    if (roll < 70) return window_base + COORD_W'($urandom_range(0, 63));
    return COORD_W'($urandom());
  endfunction

  initial begin
    logic [COORD_W-1:0] a, b, c, e;
    logic [CFG_DATA_W-1:0] cnt, al, at, ar, ab;
    int roll;
    int n;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: one-cell area at the origin, no rectangles
    query_cell(16'h0000, 16'h0000);
    query_cell(16'h0001, 16'h0000);

    set_config(16'd32, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    write_rect(5'd0,  16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    write_rect(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_rect(5'd1,  16'h0010, 16'h0000, 16'h0005, 16'hFFFF);
    write_rect(5'd2,  16'h0000, 16'h0010, 16'hFFFF, 16'h0005);
    write_rect(5'd3,  16'h0064, 16'h00C8, 16'h0064, 16'h00C8);
    write_rect(5'd4,  16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
    query_cell(16'h0000, 16'h0000);
    query_cell(16'hFFFF, 16'hFFFF);
    query_cell(16'h0064, 16'h00C8);
    query_cell(16'h0064, 16'h00C9);
    query_cell(16'h0007, 16'h0007);
    query_cell(16'h5555, 16'hAAAA);

    // count above the slot total
    set_config(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    query_cell(16'hFFFF, 16'hFFFF);
    set_config(16'd1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    query_cell(16'h0064, 16'h00C8);
    // inverted area, then a cell just outside a proper area
    set_config(16'd32, 16'h000A, 16'h0000, 16'h0005, 16'hFFFF);
    query_cell(16'h0007, 16'h0000);
    set_config(16'd32, 16'h0000, 16'h000A, 16'hFFFF, 16'h0005);
    query_cell(16'h0007, 16'h0007);
    set_config(16'd32, 16'h0064, 16'h0064, 16'h00C8, 16'h00C8);
    query_cell(16'h0032, 16'h0096);
    query_cell(16'h00C8, 16'h00C8);
    query_cell(16'h00C9, 16'h00C8);

    n = 0;
    for (int p = 0; p < PHASES; p++) begin
      window_base = COORD_W'($urandom_range(0, 65535 - 63));
      case ($urandom_range(0, 3))
        0:       cnt = 16'd32;
        1:       cnt = CFG_DATA_W'($urandom_range(0, 63));
        2:       cnt = CFG_DATA_W'($urandom_range(1, 31));
        default: cnt = CFG_DATA_W'($urandom());
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        al = '0;
        at = '0;
        ar = '1;
        ab = '1;
      end else if (roll < 25) begin
        al = window_base + 16'd40;
        at = window_base;
        ar = window_base + 16'd10;
        ab = window_base + 16'd63;
      end else begin
        al = window_base + CFG_DATA_W'($urandom_range(0, 8));
        at = window_base + CFG_DATA_W'($urandom_range(0, 8));
        ar = window_base + CFG_DATA_W'($urandom_range(48, 63));
        ab = window_base + CFG_DATA_W'($urandom_range(48, 63));
      end
      set_config(cnt, al, at, ar, ab);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm = (n >= 300) && (n < 420);
        if (p == 1 && k == 100)
          wait_idle();
        if ($urandom_range(0, 99) < 35) begin
          a = pick_coord();
          b = pick_coord();
          c = pick_coord();
          e = pick_coord();
          if ($urandom_range(0, 9) < 8) begin
            if (a > b) {a, b} = {b, a};
            if (c > e) {c, e} = {e, c};
          end
          write_rect(IDX_W'($urandom_range(0, 31)), a, c, b, e);
        end else begin
          query_cell(pick_coord(), pick_coord());
        end
        n++;
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
